/* src/prime_sieve_table_core_assert.svh */
// Assertion macros used by the prime sieve port checker.
`ifndef PRIME_SIEVE_TABLE_CORE_ASSERT_SVH
`define PRIME_SIEVE_TABLE_CORE_ASSERT_SVH

// General clocked assertion; the enclosing scope provides clk and rst_n.
`define PSIEVE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A stalled signal keeps its valid high and its value stable.
`define PSIEVE_ASSERT_HOLD(label, vld, stl, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && stl) |=> (vld && $stable(sig))) else $error(msg);

`endif

/* src/psieve_pkg.sv */
// Shared types and constants of the prime sieve table.
package psieve_pkg;

    // Field widths fixed by the interface.
    localparam int DATA_W    = 16;
    localparam int IDX_W     = 13;
    localparam int CNT_OUT_W = 14;

    // Sequencer counter widths: scan values reach limit plus a stride.
    localparam int SCAN_W = 17;
    localparam int ROOT_W = 9;

    localparam logic [DATA_W-1:0] LIMIT_RESET = 16'd1023;

    // Operation codes.
    localparam logic [1:0] OP_BUILD = 2'd0;
    localparam logic [1:0] OP_TEST  = 2'd1;
    localparam logic [1:0] OP_FETCH = 2'd2;

    // Status from the build sequencer to the transaction logic.
    typedef struct packed {
        logic busy;
        logic done;
    } bld_stat_t;

endpackage

/* src/psieve_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module psieve_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; read data holds when not reading.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/psieve_build.sv */
// Build sequencer: fills the bitmap, strikes composites and compacts the prime list.
module psieve_build #(
    parameter int MAX_NUMBERS = 65536,
    parameter int PRIME_SLOTS = 8192
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                ack,
    input  logic [psieve_pkg::DATA_W-1:0]       limit,
    input  logic                                bm_rdata,
    output psieve_pkg::bld_stat_t               stat,
    output logic                                bm_we,
    output logic [$clog2(MAX_NUMBERS)-1:0]      bm_waddr,
    output logic                                bm_wdata,
    output logic                                bm_re,
    output logic [$clog2(MAX_NUMBERS)-1:0]      bm_raddr,
    output logic                                pl_we,
    output logic [$clog2(PRIME_SLOTS)-1:0]      pl_waddr,
    output logic [psieve_pkg::DATA_W-1:0]       pl_wdata,
    output logic [$clog2(PRIME_SLOTS+1)-1:0]    found_count,
    output logic [psieve_pkg::DATA_W-1:0]       built_limit,
    output logic                                sieve_built
);

    import psieve_pkg::*;

    localparam int NUM_W  = $clog2(MAX_NUMBERS);
    localparam int SLOT_W = $clog2(PRIME_SLOTS);
    localparam int CNT_W  = $clog2(PRIME_SLOTS + 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_FILL   = 7'b0000010,
        S_TEST   = 7'b0000100,
        S_CHECK  = 7'b0001000,
        S_STRIKE = 7'b0010000,
        S_SCAN   = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [DATA_W-1:0]   top_reg, top_next;
    logic                built_reg, built_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SCAN_W-1:0]   addr_reg, addr_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [SCAN_W-1:0]   sq_reg, sq_next;
    logic                issue_reg, issue_next;
    logic                pend_reg, pend_next;
    logic [DATA_W-1:0]   pend_addr_reg, pend_addr_next;

    logic [DATA_W-1:0]   top_clamp;
    logic [SCAN_W-1:0]   top_ext;
    logic [ROOT_W-1:0]   root_inc;
    logic [SCAN_W-1:0]   sq_inc;
    logic [SCAN_W-1:0]   j_inc;
    logic                sq_over;

    // Clamp the limit to the bitmap size.
    assign top_clamp = (32'(limit) > MAX_NUMBERS - 1) ? DATA_W'(MAX_NUMBERS - 1) : limit;
    assign top_ext   = SCAN_W'(top_reg);

    // Next root and its square, (i+1)^2 = i^2 + 2i + 1.
    assign root_inc = root_reg + ROOT_W'(1);
    assign sq_inc   = sq_reg + SCAN_W'({root_reg, 1'b0}) + SCAN_W'(1);
    assign sq_over  = sq_inc > top_ext;
    assign j_inc    = addr_reg + SCAN_W'(root_reg);

    // Sequencer next state and memory requests.
    always_comb
    begin
        state_next     = state_reg;
        top_next       = top_reg;
        built_next     = built_reg;
        count_next     = count_reg;
        addr_next      = addr_reg;
        root_next      = root_reg;
        sq_next        = sq_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        bm_we          = 1'b0;
        bm_waddr       = NUM_W'(addr_reg);
        bm_wdata       = 1'b0;
        bm_re          = 1'b0;
        bm_raddr       = NUM_W'(addr_reg);
        pl_we          = 1'b0;
        pl_waddr       = SLOT_W'(count_reg);
        pl_wdata       = pend_addr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    top_next   = top_clamp;
                    built_next = 1'b1;
                    count_next = '0;
                    addr_next  = '0;
                    if (top_clamp < DATA_W'(2))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FILL;
                    end
                end
            end

            S_FILL:
            begin
                // Every number from two on starts out as a candidate prime.
                bm_we    = 1'b1;
                bm_wdata = addr_reg >= SCAN_W'(2);
                if (addr_reg == top_ext)
                begin
                    root_next = ROOT_W'(2);
                    sq_next   = SCAN_W'(4);
                    if (SCAN_W'(4) > top_ext)
                    begin
                        addr_next  = SCAN_W'(2);
                        issue_next = 1'b1;
                        pend_next  = 1'b0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_TEST;
                    end
                end
                else
                begin
                    addr_next = addr_reg + SCAN_W'(1);
                end
            end

            S_TEST:
            begin
                bm_re      = 1'b1;
                bm_raddr   = NUM_W'(root_reg);
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                if (bm_rdata)
                begin
                    addr_next  = sq_reg;
                    state_next = S_STRIKE;
                end
                else
                begin
                    root_next = root_inc;
                    sq_next   = sq_inc;
                    if (sq_over)
                    begin
                        addr_next  = SCAN_W'(2);
                        issue_next = 1'b1;
                        pend_next  = 1'b0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_TEST;
                    end
                end
            end

            S_STRIKE:
            begin
                // Strike one multiple per cycle, starting at the square.
                bm_we    = 1'b1;
                bm_wdata = 1'b0;
                if (j_inc > top_ext)
                begin
                    root_next = root_inc;
                    sq_next   = sq_inc;
                    if (sq_over)
                    begin
                        addr_next  = SCAN_W'(2);
                        issue_next = 1'b1;
                        pend_next  = 1'b0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_TEST;
                    end
                end
                else
                begin
                    addr_next = j_inc;
                end
            end

            S_SCAN:
            begin
                // Read data of the previous cycle: append a prime while slots remain.
                if (pend_reg && bm_rdata && (count_reg < CNT_W'(PRIME_SLOTS)))
                begin
                    pl_we      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                if (issue_reg)
                begin
                    bm_re          = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = DATA_W'(addr_reg);
                    if (addr_reg == top_ext)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        addr_next = addr_reg + SCAN_W'(1);
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (ack)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            top_reg   <= '0;
            built_reg <= 1'b0;
            count_reg <= '0;
            issue_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            top_reg   <= top_next;
            built_reg <= built_next;
            count_reg <= count_next;
            issue_reg <= issue_next;
            pend_reg  <= pend_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        root_reg      <= root_next;
        sq_reg        <= sq_next;
        pend_addr_reg <= pend_addr_next;
    end

    assign stat.busy   = state_reg != S_IDLE;
    assign stat.done   = state_reg == S_DONE;
    assign found_count = count_reg;
    assign built_limit = top_reg;
    assign sieve_built = built_reg;

endmodule

/* src/prime_sieve_table_core.sv */
// Top level of the prime sieve table: transaction handling, memories and output register.
//
//  Channel  Signals                                   Direction  Transaction when
//  in       in_valid, in_stall, op, number, prime_index   in     in_valid && !in_stall
//  out      out_valid, out_stall, is_prime, ...           out    out_valid && !out_stall
//  cfg      cfg_valid, cfg_ready, cfg_limit               in     cfg_valid && cfg_ready
//
// Test and fetch transactions flow back to back while the output does not stall; the
// result passes through the query stage (one bitmap or list read) into the output register.
// A build holds off the input channel while it fills the bitmap, strikes each multiple
// of the prime roots one at a time and scans the bitmap into the prime list.
// Reset clears control state only; the memories need no clearing pass.
// A stalled output holds its result and back-pressures the input channel.
module prime_sieve_table_core #(
    parameter int MAX_NUMBERS = 65536,
    parameter int PRIME_SLOTS = 8192
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           op,
    input  logic [psieve_pkg::DATA_W-1:0]        number,
    input  logic [psieve_pkg::IDX_W-1:0]         prime_index,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 is_prime,
    output logic [psieve_pkg::DATA_W-1:0]        prime_value,
    output logic [psieve_pkg::CNT_OUT_W-1:0]     prime_count,
    output logic                                 valid_res,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [psieve_pkg::DATA_W-1:0]        cfg_limit
);

    import psieve_pkg::*;

    localparam int NUM_W  = $clog2(MAX_NUMBERS);
    localparam int SLOT_W = $clog2(PRIME_SLOTS);
    localparam int CNT_W  = $clog2(PRIME_SLOTS + 1);

    logic [DATA_W-1:0]    limit_reg;
    logic                 bld_req_reg, bld_req_next;
    logic                 s1_valid_reg, s1_valid_next;
    logic [1:0]           s1_op_reg;
    logic                 s1_hit_reg, s1_hit_next;
    logic                 s1_built_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 is_prime_reg, is_prime_next;
    logic [DATA_W-1:0]    prime_value_reg, prime_value_next;
    logic [CNT_OUT_W-1:0] prime_count_reg, prime_count_next;
    logic                 valid_res_reg, valid_res_next;

    bld_stat_t            stat;
    logic                 start;
    logic                 ack;
    logic                 out_free;
    logic                 s1_adv;
    logic                 in_acc;
    logic                 q_test_hit;
    logic                 q_fetch_hit;

    logic                 b_bm_we, b_bm_wdata, b_bm_re;
    logic [NUM_W-1:0]     b_bm_waddr, b_bm_raddr;
    logic                 bm_re;
    logic [NUM_W-1:0]     bm_raddr;
    logic                 bm_rdata;
    logic                 pl_we, pl_re;
    logic [SLOT_W-1:0]    pl_waddr;
    logic [DATA_W-1:0]    pl_wdata, pl_rdata;
    logic [CNT_W-1:0]     found_count;
    logic [DATA_W-1:0]    built_limit;
    logic                 sieve_built;

    // Handshake control.
    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_adv    = s1_valid_reg && out_free;
    assign in_stall  = bld_req_reg || stat.busy || (s1_valid_reg && !out_free);
    assign in_acc    = in_valid && !in_stall;
    assign start     = bld_req_reg && !s1_valid_reg && !stat.busy;
    assign ack       = stat.done && out_free;
    assign cfg_ready = 1'b1;

    // Range checks at acceptance decide whether a memory read is needed.
    assign q_test_hit  = sieve_built && (number > DATA_W'(1)) && (number <= built_limit);
    assign q_fetch_hit = sieve_built && (32'(prime_index) < 32'(found_count));

    // The bitmap read port belongs to the sequencer during a build.
    assign bm_re    = stat.busy ? b_bm_re : (in_acc && (op == OP_TEST) && q_test_hit);
    assign bm_raddr = stat.busy ? b_bm_raddr : NUM_W'(number);
    assign pl_re    = in_acc && (op == OP_FETCH) && q_fetch_hit;

    // Query stage and build request.
    always_comb
    begin
        bld_req_next  = bld_req_reg;
        s1_valid_next = s1_valid_reg;
        if (start)
        begin
            bld_req_next = 1'b0;
        end
        if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        if (in_acc)
        begin
            if (op == OP_BUILD)
            begin
                bld_req_next = 1'b1;
            end
            else
            begin
                s1_valid_next = 1'b1;
            end
        end

        case (op)
            OP_TEST:  s1_hit_next = q_test_hit;
            OP_FETCH: s1_hit_next = q_fetch_hit;
            default:  s1_hit_next = 1'b0;
        endcase
    end

    // Output register loads a build completion or a finished query.
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        is_prime_next    = is_prime_reg;
        prime_value_next = prime_value_reg;
        prime_count_next = prime_count_reg;
        valid_res_next   = valid_res_reg;
        if (ack)
        begin
            out_valid_next   = 1'b1;
            is_prime_next    = 1'b0;
            prime_value_next = '0;
            prime_count_next = CNT_OUT_W'(found_count);
            valid_res_next   = 1'b1;
        end
        else if (s1_adv)
        begin
            out_valid_next   = 1'b1;
            is_prime_next    = 1'b0;
            prime_value_next = '0;
            prime_count_next = CNT_OUT_W'(found_count);
            valid_res_next   = 1'b0;
            case (s1_op_reg)
                OP_TEST:
                begin
                    is_prime_next  = s1_hit_reg && bm_rdata;
                    valid_res_next = s1_built_reg;
                end
                OP_FETCH:
                begin
                    prime_value_next = s1_hit_reg ? pl_rdata : '0;
                    valid_res_next   = s1_hit_reg;
                end
                default:
                begin
                    valid_res_next = 1'b0;
                end
            endcase
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            bld_req_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_limit;
            end
            bld_req_reg   <= bld_req_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_op_reg    <= op;
            s1_hit_reg   <= s1_hit_next;
            s1_built_reg <= sieve_built;
        end
        is_prime_reg    <= is_prime_next;
        prime_value_reg <= prime_value_next;
        prime_count_reg <= prime_count_next;
        valid_res_reg   <= valid_res_next;
    end

    assign out_valid   = out_valid_reg;
    assign is_prime    = is_prime_reg;
    assign prime_value = prime_value_reg;
    assign prime_count = prime_count_reg;
    assign valid_res   = valid_res_reg;

    psieve_build #(
        .MAX_NUMBERS (MAX_NUMBERS),
        .PRIME_SLOTS (PRIME_SLOTS)
    ) u_build (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .ack         (ack),
        .limit       (limit_reg),
        .bm_rdata    (bm_rdata),
        .stat        (stat),
        .bm_we       (b_bm_we),
        .bm_waddr    (b_bm_waddr),
        .bm_wdata    (b_bm_wdata),
        .bm_re       (b_bm_re),
        .bm_raddr    (b_bm_raddr),
        .pl_we       (pl_we),
        .pl_waddr    (pl_waddr),
        .pl_wdata    (pl_wdata),
        .found_count (found_count),
        .built_limit (built_limit),
        .sieve_built (sieve_built)
    );

    // Primality bitmap, one bit per number.
    psieve_ram #(
        .WIDTH (1),
        .DEPTH (MAX_NUMBERS)
    ) u_bitmap (
        .clk   (clk),
        .we    (b_bm_we),
        .waddr (b_bm_waddr),
        .wdata (b_bm_wdata),
        .re    (bm_re),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    // Ascending list of primes.
    psieve_ram #(
        .WIDTH (DATA_W),
        .DEPTH (PRIME_SLOTS)
    ) u_list (
        .clk   (clk),
        .we    (pl_we),
        .waddr (pl_waddr),
        .wdata (pl_wdata),
        .re    (pl_re),
        .raddr (SLOT_W'(prime_index)),
        .rdata (pl_rdata)
    );

endmodule

/* src/psieve_checker.sv */
// Port-level checker for the prime sieve table and its bind statement.
`include "prime_sieve_table_core_assert.svh"

module psieve_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic                                 is_prime,
    input logic [psieve_pkg::DATA_W-1:0]        prime_value,
    input logic [psieve_pkg::CNT_OUT_W-1:0]     prime_count,
    input logic                                 valid_res
);

    import psieve_pkg::*;

    // A stalled result keeps its value.
    `PSIEVE_ASSERT_HOLD(a_out_hold, out_valid, out_stall, prime_value, "stalled result changed")

    // An invalid result carries no answer.
    `PSIEVE_ASSERT(a_invalid_empty,
        out_valid && !valid_res |-> !is_prime && prime_value == '0,
        "invalid result carries data")

    // A transaction answers either a test or a fetch, never both.
    `PSIEVE_ASSERT(a_one_answer,
        out_valid |-> !(is_prime && prime_value != '0),
        "test and fetch answers mixed")

    // Any fetched prime is two or odd.
    `PSIEVE_ASSERT(a_prime_odd,
        out_valid && prime_value != '0 |-> prime_value[0] || prime_value == DATA_W'(2),
        "fetched value is even")

    // A fetched prime can only come from a list that holds at least one entry.
    `PSIEVE_ASSERT(a_fetch_counted,
        out_valid && prime_value != '0 |-> prime_count != '0,
        "fetched prime with empty count")

endmodule

bind prime_sieve_table_core psieve_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .is_prime    (is_prime),
    .prime_value (prime_value),
    .prime_count (prime_count),
    .valid_res   (valid_res)
);

/* bench/prime_sieve_checker.sv */
`timescale 1ns / 1ps
// Result checker of the prime sieve table: keeps its own sieve and compares every result.
module prime_sieve_checker #(
    parameter int NUM_SPAN   = 65536,
    parameter int LIST_SLOTS = 8192
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic [1:0]                           op,
    input  logic [psieve_pkg::DATA_W-1:0]        number,
    input  logic [psieve_pkg::IDX_W-1:0]         prime_index,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic                                 is_prime,
    input  logic [psieve_pkg::DATA_W-1:0]        prime_value,
    input  logic [psieve_pkg::CNT_OUT_W-1:0]     prime_count,
    input  logic                                 valid_res,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [psieve_pkg::DATA_W-1:0]        cfg_limit,
    output int                                   mismatches,
    output int                                   pending
);

    import psieve_pkg::*;

    typedef struct packed {
        logic                 is_prime;
        logic [DATA_W-1:0]    prime_value;
        logic [CNT_OUT_W-1:0] prime_count;
        logic                 valid_res;
    } sieve_answer_t;

    // Shadow copy of the sieve, the prime list and the limit register.
    bit                sieve_map [NUM_SPAN];
    logic [DATA_W-1:0] prime_table [LIST_SLOTS];
    int                found_primes = 0;
    bit                sieve_ready = 1'b0;
    int                sieve_top = 0;
    logic [DATA_W-1:0] limit_reg = LIMIT_RESET;

    // Answers waiting for their result transaction, oldest first.
    sieve_answer_t answers_due[$];

    // Runs the sieve over 0..limit and compacts the primes into the list.
    function automatic void run_sieve();
        int top;
        int n;
        int i;
        int j;
        top = int'(limit_reg);
        if (top > NUM_SPAN - 1)
            top = NUM_SPAN - 1;
        sieve_top = top;
        sieve_ready = 1'b1;
        found_primes = 0;
        if (top < 2)
            return;
        for (i = 0; i <= top; i++)
            sieve_map[i] = 1'b1;
        sieve_map[0] = 1'b0;
        sieve_map[1] = 1'b0;
        for (i = 2; i * i <= top; i++)
        begin
            if (sieve_map[i])
            begin
                for (j = i * i; j <= top; j += i)
                    sieve_map[j] = 1'b0;
            end
        end
        n = 0;
        for (i = 2; i <= top; i++)
        begin
            if (sieve_map[i] && n < LIST_SLOTS)
            begin
                prime_table[n] = i[DATA_W-1:0];
                n++;
            end
        end
        found_primes = n;
    endfunction

    // Works out the result of one input transaction and updates the shadow state.
    function automatic sieve_answer_t predict_answer(logic [1:0] code,
                                                     logic [DATA_W-1:0] num,
                                                     logic [IDX_W-1:0] idx);
        sieve_answer_t a;
        a = '0;
        case (code)
            OP_BUILD:
            begin
                run_sieve();
                a.valid_res = 1'b1;
            end
            OP_TEST:
            begin
                a.valid_res = sieve_ready;
                if (sieve_ready && num > 1 && num <= sieve_top)
                    a.is_prime = sieve_map[num];
            end
            OP_FETCH:
            begin
                if (sieve_ready && idx < found_primes)
                begin
                    a.prime_value = prime_table[idx];
                    a.valid_res = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        a.prime_count = found_primes[CNT_OUT_W-1:0];
        return a;
    endfunction

    task automatic check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", field, want_v, got_v);
            mismatches++;
        end
    endtask

    // Watch all three channels; inputs are handled before outputs at each edge.
    always @(posedge clk)
    begin
        sieve_answer_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                limit_reg = cfg_limit;
            if (in_valid && !in_stall)
                answers_due.push_back(predict_answer(op, number, prime_index));
            if (out_valid && !out_stall)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("result transaction with no expectation waiting");
                    mismatches++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    check_field("is_prime", 32'(want.is_prime), 32'(is_prime));
                    check_field("prime_value", 32'(want.prime_value), 32'(prime_value));
                    check_field("prime_count", 32'(want.prime_count), 32'(prime_count));
                    check_field("valid_res", 32'(want.valid_res), 32'(valid_res));
                end
            end
            pending <= answers_due.size();
        end
    end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Testbench top of the prime sieve table: clock, reset, stimulus, stall pattern and verdict.
module tb;
    import psieve_pkg::*;

    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 1_500_000;
    localparam int SETTLE_CYCLES   = 16;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 125;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [1:0]           op = OP_BUILD;
    logic [DATA_W-1:0]    number = '0;
    logic [IDX_W-1:0]     prime_index = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 is_prime;
    logic [DATA_W-1:0]    prime_value;
    logic [CNT_OUT_W-1:0] prime_count;
    logic                 valid_res;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [DATA_W-1:0]    cfg_limit = '0;

    int mismatches;
    int pending;

    // Stimulus controls: quiet turns idling off, steady keeps the sender busy,
    // press_go asks the receiver for one long hold, press_done marks it served.
    bit quiet = 1'b0;
    bit steady = 1'b0;
    bit press_go = 1'b0;
    bit press_done = 1'b0;
    int limit_now = int'(LIMIT_RESET);
    int built_top = 0;
    int quiet_cycles = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    prime_sieve_table_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .number      (number),
        .prime_index (prime_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .is_prime    (is_prime),
        .prime_value (prime_value),
        .prime_count (prime_count),
        .valid_res   (valid_res),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_limit   (cfg_limit)
    );

    prime_sieve_checker sieve_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .number      (number),
        .prime_index (prime_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .is_prime    (is_prime),
        .prime_value (prime_value),
        .prime_count (prime_count),
        .valid_res   (valid_res),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_limit   (cfg_limit),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    // Receiver: random stall bursts, plus one long hold when asked.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (press_go && !press_done)
            begin
                press_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 15) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: ends the run after a long stretch with no transaction on any channel.
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Offers one input transaction and waits until it is taken; may idle afterwards.
    task automatic offer(input logic [1:0] code, input logic [DATA_W-1:0] num,
                         input logic [IDX_W-1:0] idx);
        in_valid <= 1'b1;
        op <= code;
        number <= num;
        prime_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (code == OP_BUILD)
            built_top = limit_now;
        if (!quiet && !steady && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(input int value);
        cfg_valid <= 1'b1;
        cfg_limit <= value[DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        limit_now = value;
    endtask

    // One random transaction; numbers and indexes lean toward the built range.
    task automatic random_item(input bit allow_build);
        int pick;
        int num_hi;
        int idx_hi;
        logic [1:0] code;
        logic [DATA_W-1:0] num;
        logic [IDX_W-1:0] idx;
        pick = $urandom_range(0, 99);
        if (allow_build && pick < 2)
            code = OP_BUILD;
        else if (pick < 55)
            code = OP_TEST;
        else if (pick < 95)
            code = OP_FETCH;
        else
            code = OP_SPARE;
        num_hi = (built_top + 2 > 65535) ? 65535 : built_top + 2;
        idx_hi = (built_top / 4 + 2 > 8191) ? 8191 : built_top / 4 + 2;
        if ($urandom_range(0, 1))
            num = DATA_W'($urandom_range(0, num_hi));
        else
            num = DATA_W'($urandom);
        if ($urandom_range(0, 1))
            idx = IDX_W'($urandom_range(0, idx_hi));
        else
            idx = IDX_W'($urandom);
        offer(code, num, idx);
    endtask

    initial
    begin
        int lim;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Before the first build, tests and fetches answer not valid.
        offer(OP_TEST, 16'd2, 13'd0);
        offer(OP_FETCH, 16'd0, 13'd0);
        offer(OP_SPARE, 16'hFFFF, 13'h1FFF);

        // Build at the reset limit, then probe the edges of the table.
        offer(OP_BUILD, 16'd0, 13'd0);
        offer(OP_TEST, 16'd0, 13'd0);
        offer(OP_TEST, 16'd1, 13'd0);
        offer(OP_TEST, 16'd2, 13'd0);
        offer(OP_TEST, 16'd4, 13'd0);
        offer(OP_TEST, 16'd1021, 13'd0);
        offer(OP_TEST, 16'd1023, 13'd0);
        offer(OP_TEST, 16'd1024, 13'd0);
        offer(OP_TEST, 16'hFFFF, 13'd0);
        // 172 primes lie below 1024: index 171 is the last one kept.
        offer(OP_FETCH, 16'd0, 13'd0);
        offer(OP_FETCH, 16'd0, 13'd171);
        offer(OP_FETCH, 16'd0, 13'd172);
        offer(OP_FETCH, 16'd0, 13'h1FFF);
        offer(OP_SPARE, 16'd5, 13'd5);
        settle();

        // A new limit must not affect queries until the next build.
        write_limit(0);
        offer(OP_TEST, 16'd1021, 13'd0);
        offer(OP_FETCH, 16'd0, 13'd171);
        offer(OP_BUILD, 16'd0, 13'd0);
        offer(OP_TEST, 16'd0, 13'd0);
        offer(OP_FETCH, 16'd0, 13'd0);
        settle();
        write_limit(1);
        offer(OP_BUILD, 16'd0, 13'd0);
        offer(OP_TEST, 16'd1, 13'd0);
        settle();
        write_limit(2);
        offer(OP_BUILD, 16'd0, 13'd0);
        offer(OP_TEST, 16'd2, 13'd0);
        offer(OP_FETCH, 16'd0, 13'd1);
        settle();

        // Random phases, each with its own limit; one uses the full range.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 3)
                lim = 65535;
            else if (ph == 7)
                lim = $urandom_range(0, 3);
            else
                lim = $urandom_range(4, 2047);
            if (ph == PHASES - 1)
                quiet = 1'b1;
            settle();
            write_limit(lim);
            repeat (3) random_item(1'b0);
            offer(OP_BUILD, DATA_W'($urandom), IDX_W'($urandom));
            if (ph == 1)
            begin
                // Let the build finish, then hold the output long enough for the
                // block to fill and stall its input.
                settle();
                steady = 1'b1;
                press_go = 1'b1;
                repeat (60) random_item(1'b0);
                steady = 1'b0;
            end
            repeat (ITEMS_PER_PHASE) random_item(limit_now <= 4096);
        end

        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending != 0)
            $error("%0d expected results never arrived", pending);
        if (mismatches == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
